>>> rtl/signed_int_to_decimal_ascii_top_defines.svh
// assertion macros for the signed integer to decimal text block
// used by the port checker; needs clk and rst_n in the using scope
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define S2DA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("s2da check failed");

// next-cycle implication, checked outside reset
`define S2DA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("s2da check failed");

`endif

>>> rtl/s2da_pkg.sv
// shared types and constants for the signed integer to decimal text block
// no dependencies
package s2da_pkg;

    localparam int unsigned MAG_W      = 32;
    localparam int unsigned BCD_DIGITS = 10;
    localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
    localparam int unsigned DAB_STEPS  = 8;
    localparam int unsigned DAB_STAGES = MAG_W / DAB_STEPS;
    localparam int unsigned CNT_W      = 4;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    // word moving through the shift-and-add-3 stages
    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
        logic [MAG_W-1:0] bin;
    } dab_word_t;

    // digits left-aligned so the leading digit is in the top nibble
    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
        logic [CNT_W-1:0] cnt;  // digit count minus one
    } txt_word_t;

endpackage

>>> rtl/s2da_dabble.sv
// one pipeline stage of the binary to bcd conversion, several shift-and-add-3 steps
// depends on s2da_pkg
module s2da_dabble
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  s2da_pkg::dab_word_t  in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output s2da_pkg::dab_word_t  out_word
);

    logic                valid_reg;
    s2da_pkg::dab_word_t word_reg;
    s2da_pkg::dab_word_t word_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb
    begin
        word_next = in_word;
        for (int s = 0; s < int'(s2da_pkg::DAB_STEPS); s++)
        begin
            for (int d = 0; d < int'(s2da_pkg::BCD_DIGITS); d++)
            begin
                if (word_next.bcd[4*d +: 4] >= 4'd5)
                begin
                    word_next.bcd[4*d +: 4] = word_next.bcd[4*d +: 4] + 4'd3;
                end
            end
            {word_next.bcd, word_next.bin} = {word_next.bcd, word_next.bin} << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

endmodule

>>> rtl/s2da_align.sv
// finds the leading digit and left-aligns the bcd digits, one register stage
// depends on s2da_pkg
module s2da_align
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  s2da_pkg::dab_word_t  in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output s2da_pkg::txt_word_t  out_word
);

    logic                           valid_reg;
    s2da_pkg::txt_word_t            word_reg;
    s2da_pkg::txt_word_t            word_next;
    logic [s2da_pkg::CNT_W-1:0]     top;
    logic [s2da_pkg::CNT_W-1:0]     pad;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    // highest nonzero digit; zero keeps a single digit
    always_comb
    begin
        top = '0;
        for (int d = 1; d < int'(s2da_pkg::BCD_DIGITS); d++)
        begin
            if (in_word.bcd[4*d +: 4] != 4'd0)
            begin
                top = s2da_pkg::CNT_W'(d);
            end
        end
        pad = s2da_pkg::CNT_W'(s2da_pkg::BCD_DIGITS - 1) - top;
        word_next.neg = in_word.neg;
        word_next.cnt = top;
        word_next.bcd = in_word.bcd << {pad, 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

endmodule

>>> rtl/s2da_serial.sv
// sends the text one character per word: optional minus, then the digits
// depends on s2da_pkg
module s2da_serial
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  s2da_pkg::txt_word_t  in_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           char_code,
    output logic                 last
);

    logic                          busy_reg;
    logic                          busy_next;
    logic                          minus_reg;
    logic                          minus_next;
    logic [s2da_pkg::BCD_W-1:0]    bcd_reg;
    logic [s2da_pkg::BCD_W-1:0]    bcd_next;
    logic [s2da_pkg::CNT_W-1:0]    left_reg;
    logic [s2da_pkg::CNT_W-1:0]    left_next;
    logic                          take;
    logic                          final_char;
    logic                          load;

    assign final_char = !minus_reg && (left_reg == '0);
    assign take       = busy_reg && !out_stall;
    assign in_ready   = !busy_reg || (take && final_char);
    assign load       = in_ready && in_valid;

    assign out_valid = busy_reg;
    assign last      = final_char;
    assign char_code = minus_reg ? s2da_pkg::CHAR_MINUS
                     : s2da_pkg::CHAR_ZERO + {4'b0000, bcd_reg[s2da_pkg::BCD_W-1 -: 4]};

    always_comb
    begin
        busy_next  = busy_reg;
        minus_next = minus_reg;
        bcd_next   = bcd_reg;
        left_next  = left_reg;
        if (load)
        begin
            busy_next  = 1'b1;
            minus_next = in_word.neg;
            bcd_next   = in_word.bcd;
            left_next  = in_word.cnt;
        end
        else if (take)
        begin
            if (minus_reg)
            begin
                minus_next = 1'b0;
            end
            else if (left_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                bcd_next  = bcd_reg << 4;
                left_next = left_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        minus_reg <= minus_next;
        bcd_reg   <= bcd_next;
        left_reg  <= left_next;
    end

endmodule

>>> rtl/signed_int_to_decimal_ascii_top.sv
// Signed 32-bit integer to decimal ASCII text. Each input word is one two's
// complement value; the output sends its text one character per word, most
// significant first, a minus sign ahead of negative values, no leading zeros,
// and last set on the final character (1 to 11 characters). The value goes
// through an input register, four shift-and-add-3 stages of eight bits each and
// an alignment stage before the serializer. A new value enters every cycle
// while the pipeline has room; the output serializer sends one character per
// cycle unless out_stall is high, so the length of each number's text sets the
// sustained rate. Depends on s2da_pkg, s2da_dabble, s2da_align and s2da_serial.
module signed_int_to_decimal_ascii_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         char_code,
    output logic               last
);

    localparam int unsigned NST = s2da_pkg::DAB_STAGES;

    logic                 in_valid_reg;
    s2da_pkg::dab_word_t  in_word_reg;
    s2da_pkg::dab_word_t  in_word_next;
    logic                 in_ready;

    logic                 dab_valid [NST+1];
    logic                 dab_ready [NST+1];
    s2da_pkg::dab_word_t  dab_word  [NST+1];

    logic                 txt_valid;
    logic                 txt_ready;
    s2da_pkg::txt_word_t  txt_word;

    assign in_ready = !in_valid_reg || dab_ready[0];
    assign in_stall = !in_ready;

    // magnitude fits 32 bits unsigned, including the most negative value
    always_comb
    begin
        in_word_next.neg = value[31];
        in_word_next.bcd = '0;
        in_word_next.bin = value[31] ? (~value + 32'd1) : value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_word_reg <= in_word_next;
        end
    end

    assign dab_valid[0] = in_valid_reg;
    assign dab_word[0]  = in_word_reg;

    for (genvar g = 0; g < NST; g++)
    begin : g_dab
        s2da_dabble u_dab
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dab_valid[g]),
            .in_ready  (dab_ready[g]),
            .in_word   (dab_word[g]),
            .out_valid (dab_valid[g+1]),
            .out_ready (dab_ready[g+1]),
            .out_word  (dab_word[g+1])
        );
    end

    s2da_align u_align
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dab_valid[NST]),
        .in_ready  (dab_ready[NST]),
        .in_word   (dab_word[NST]),
        .out_valid (txt_valid),
        .out_ready (txt_ready),
        .out_word  (txt_word)
    );

    s2da_serial u_serial
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (txt_valid),
        .in_ready  (txt_ready),
        .in_word   (txt_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last      (last)
    );

endmodule

>>> rtl/s2da_checker.sv
// port-level checks for the signed integer to decimal text block, bound to the top
// depends on s2da_pkg and the assertion macro header
`include "signed_int_to_decimal_ascii_top_defines.svh"

module s2da_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  char_code,
    input  logic        last
);

    logic is_minus;
    logic is_digit;

    assign is_minus = (char_code == s2da_pkg::CHAR_MINUS);
    assign is_digit = (char_code >= s2da_pkg::CHAR_ZERO)
                   && (char_code <= s2da_pkg::CHAR_ZERO + 8'd9);

    `S2DA_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(char_code) && $stable(last))
    `S2DA_ASSERT_NOW(a_char_set, out_valid, is_minus || is_digit)
    `S2DA_ASSERT_NOW(a_minus_not_last, out_valid && is_minus, !last)
    `S2DA_ASSERT_NEXT(a_digit_follows, out_valid && !out_stall && is_minus, out_valid && is_digit)

endmodule

bind signed_int_to_decimal_ascii_top s2da_checker u_s2da_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_code (char_code),
    .last      (last)
);
